// ===== rtl/aes256_pkg.sv =====
`timescale 1ns / 1ps
package aes256_pkg;

  localparam int NumRounds = 14;
  localparam int KeyWords  = 60;
  localparam int KeyIdxW   = 6;
  localparam int RoundW    = 4;
  localparam int AddrW     = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_IV_HI = 3'd4,
    REG_IV_LO = 3'd5
  } aes_reg_t;

  localparam logic ACT_ENCRYPT = 1'b0;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] REV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_fwd(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_fwd = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] mix_rev(input logic [31:0] c);
    logic [7:0] u, v;
    logic [31:0] p;
    // precondition the column so the forward mix yields the inverse
    u = xt(xt(c[31:24] ^ c[15:8]));
    v = xt(xt(c[23:16] ^ c[7:0]));
    p = {c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v};
    mix_rev = mix_fwd(p);
  endfunction

endpackage

// ===== rtl/aes256_cbc_block_cipher.sv =====
`timescale 1ns / 1ps
// AES-256 in CBC mode, one round per step on a single shared round unit. A block that is
// not marked first passes from its accept through the load state, 15 round-key steps (one
// round-key word read per cycle) and the result state before the next accept. A block marked
// first also expands the key into the 60-word round key memory, one word per cycle, and
// loads the chain from the IV. One block is in flight at a time; stall is high until its
// result beat is taken. Key and IV registers act only at the next first block.
module aes256_cbc_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic        first_block,
  input  logic [63:0] data_hi,
  input  logic [63:0] data_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_hi,
  output logic [63:0] result_lo
);
  import aes256_pkg::*;

  logic [63:0] key_reg [4];
  logic [63:0] iv_hi, iv_lo;
  logic [31:0] rk_mem [KeyWords];
  logic [127:0] rk_q;
  logic [31:0] w_hist [8];

  aes_state_t state, state_next;
  logic [KeyIdxW-1:0] kidx;
  logic [RoundW-1:0] rnd;
  logic [1:0] col;
  logic act_q;
  logic [127:0] st, chain, din_q;
  logic [2:0] reg_sel;
  logic wr_en;

  assign pready = 1'b1;
  assign reg_sel = paddr[5:3];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
      iv_hi <= '0;
      iv_lo <= '0;
    end else if (wr_en) begin
      case (aes_reg_t'(reg_sel))
        REG_KEY0: key_reg[0] <= pwdata;
        REG_KEY1: key_reg[1] <= pwdata;
        REG_KEY2: key_reg[2] <= pwdata;
        REG_KEY3: key_reg[3] <= pwdata;
        REG_IV_HI: iv_hi <= pwdata;
        REG_IV_LO: iv_lo <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (aes_reg_t'(reg_sel))
      REG_KEY0: prdata = key_reg[0];
      REG_KEY1: prdata = key_reg[1];
      REG_KEY2: prdata = key_reg[2];
      REG_KEY3: prdata = key_reg[3];
      REG_IV_HI: prdata = iv_hi;
      REG_IV_LO: prdata = iv_lo;
      default: prdata = '0;
    endcase
  end

  // key expansion, one word per cycle
  logic [31:0] w_prev, w_t, w_new;
  logic [7:0] rcon;
  always_comb begin
    w_prev = w_hist[7];
    rcon = 8'h01 << (kidx[5:3] - 3'd1);
    if (kidx[2:0] == 3'd0) begin
      w_t = {FWD_BOX[w_prev[23:16]], FWD_BOX[w_prev[15:8]],
             FWD_BOX[w_prev[7:0]], FWD_BOX[w_prev[31:24]]} ^ {rcon, 24'h0};
    end else if (kidx[2:0] == 3'd4) begin
      w_t = {FWD_BOX[w_prev[31:24]], FWD_BOX[w_prev[23:16]],
             FWD_BOX[w_prev[15:8]], FWD_BOX[w_prev[7:0]]};
    end else begin
      w_t = w_prev;
    end
    if (kidx < 6'd8) w_new = kidx[0] ? key_reg[kidx[2:1]][31:0] : key_reg[kidx[2:1]][63:32];
    else w_new = w_hist[0] ^ w_t;
  end

  // round key words are read one per cycle, four words per round;
  // the col 0 word of the next round is fetched on the step cycle
  logic [AddrW-1:0] rd_addr;
  logic [RoundW-1:0] rd_round, rd_step;
  logic [1:0] rd_col;
  logic rk_we;
  logic [31:0] rk_rd;
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[kidx] <= w_new;
    rk_rd <= rk_mem[rd_addr];
  end
  assign rd_col = (state == ST_ROUND) ? col : 2'd0;
  assign rd_addr = {rd_round, rd_col};

  logic [127:0] s_sub, s_shift, s_mix, s_tmp, s_key;
  always_comb begin
    s_sub = '0; s_shift = '0; s_mix = '0; s_tmp = '0;
    if (act_q == ACT_ENCRYPT) begin
      for (int i = 0; i < 16; i++) s_sub[127-8*i -: 8] = FWD_BOX[st[127-8*i -: 8]];
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          s_shift[127-8*(r+4*c) -: 8] = s_sub[127-8*(r+4*((c+r)%4)) -: 8];
      for (int c = 0; c < 4; c++) s_mix[127-32*c -: 32] = mix_fwd(s_shift[127-32*c -: 32]);
      s_key = (rnd == RoundW'(NumRounds)) ? s_shift : s_mix;
    end else begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          s_shift[127-8*(r+4*((c+r)%4)) -: 8] = st[127-8*(r+4*c) -: 8];
      for (int i = 0; i < 16; i++) s_tmp[127-8*i -: 8] = REV_BOX[s_shift[127-8*i -: 8]];
      s_key = s_tmp;
    end
  end

  // round step: each of rounds 0..14 collects its four key words, step on col==0
  logic [127:0] rk_full;
  logic [127:0] after_key;
  assign rk_full = {rk_q[95:0], rk_rd};
  always_comb begin
    if (rnd == '0) after_key = st ^ rk_full;
    else if (act_q == ACT_ENCRYPT) after_key = s_key ^ rk_full;
    else begin
      after_key = s_key ^ rk_full;
      if (rnd != RoundW'(NumRounds)) begin
        for (int c = 0; c < 4; c++) after_key[127-32*c -: 32] = mix_rev(after_key[127-32*c -: 32]);
      end
    end
  end

  logic rd_pend;
  always_comb begin
    state_next = state;
    rk_we = 1'b0;
    rd_step = '0;
    if (state == ST_ROUND) begin
      rd_step = (col == 2'd0 && rnd != RoundW'(NumRounds)) ? rnd + 4'd1 : rnd;
    end
    rd_round = act_q == ACT_ENCRYPT ? rd_step : RoundW'(NumRounds) - rd_step;
    case (state)
      ST_IDLE: if (in_valid) state_next = first_block ? ST_EXPAND : ST_LOAD;
      ST_EXPAND: begin
        rk_we = 1'b1;
        if (kidx == 6'(KeyWords - 1)) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (rd_pend && col == 2'd0 && rnd == RoundW'(NumRounds)) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign result_hi = st[127:64];
  assign result_lo = st[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chain <= '0;
      kidx <= '0;
      rnd <= '0;
      col <= '0;
      rd_pend <= 1'b0;
      act_q <= ACT_ENCRYPT;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          kidx <= '0;
          if (in_valid) begin
            act_q <= action;
            din_q <= {data_hi, data_lo};
            if (first_block) chain <= {iv_hi, iv_lo};
          end
        end
        ST_EXPAND: begin
          kidx <= kidx + 6'd1;
          for (int i = 0; i < 7; i++) w_hist[i] <= w_hist[i+1];
          w_hist[7] <= w_new;
        end
        ST_LOAD: begin
          st <= (act_q == ACT_ENCRYPT) ? (din_q ^ chain) : din_q;
          rnd <= '0;
          col <= 2'd1;
          rd_pend <= 1'b0;
        end
        ST_ROUND: begin
          // read data for word (col-1) arrives this cycle
          rk_q <= rk_full;
          rd_pend <= 1'b1;
          col <= col + 2'd1;
          if (rd_pend && col == 2'd0) begin
            if (rnd == RoundW'(NumRounds)) begin
              if (act_q == ACT_ENCRYPT) begin
                st <= after_key;
                chain <= after_key;
              end else begin
                st <= after_key ^ chain;
                chain <= din_q;
              end
            end else begin
              st <= after_key;
              rnd <= rnd + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("result shown while input open");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_stall) |=> ($stable(result_hi) && $stable(result_lo)))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (rst) state == ST_ROUND |-> rnd <= RoundW'(NumRounds))
    else $error("round count overrun");
  assert property (@(posedge clk) disable iff (rst) rk_we |-> kidx < 6'(KeyWords))
    else $error("key write out of range");
endmodule
